// ===== design/vms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vms_pkg;

   // Item kinds
   localparam logic [1:0] ACT_POSE = 2'd0;
   localparam logic [1:0] ACT_CMD  = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   // Motion command codes
   localparam logic [2:0] CMD_UNDEF = 3'd0;
   localparam logic [2:0] CMD_HOLD  = 3'd1;
   localparam logic [2:0] CMD_POINT = 3'd2;
   localparam logic [2:0] CMD_WORLD = 3'd3;
   localparam logic [2:0] CMD_BODY  = 3'd4;
   localparam logic [2:0] CMD_GEO   = 3'd5;

   // Drive actions
   localparam logic [2:0] DRV_NONE  = 3'd0;
   localparam logic [2:0] DRV_ZERO  = 3'd1;
   localparam logic [2:0] DRV_BODY  = 3'd2;
   localparam logic [2:0] DRV_POINT = 3'd3;
   localparam logic [2:0] DRV_WORLD = 3'd4;

   // Diagnostic levels and reasons
   localparam logic [1:0] LVL_OK   = 2'd0;
   localparam logic [1:0] LVL_WARN = 2'd1;
   localparam logic [1:0] LVL_ERR  = 2'd2;

   localparam logic [3:0] RSN_OK       = 4'd0;
   localparam logic [3:0] RSN_GEO      = 4'd1;
   localparam logic [3:0] RSN_UNKNOWN  = 4'd2;
   localparam logic [3:0] RSN_FENCE    = 4'd3;
   localparam logic [3:0] RSN_NO_STAMP = 4'd4;
   localparam logic [3:0] RSN_TIMEOUT  = 4'd5;
   localparam logic [3:0] RSN_NO_WORLD = 4'd6;
   localparam logic [3:0] RSN_LATERAL  = 4'd7;
   localparam logic [3:0] RSN_BAD_MOVE = 4'd8;

   // Register indexes
   localparam logic [2:0] CSR_FENCE_MIN_X = 3'd0;
   localparam logic [2:0] CSR_FENCE_MAX_X = 3'd1;
   localparam logic [2:0] CSR_FENCE_MIN_Y = 3'd2;
   localparam logic [2:0] CSR_FENCE_MAX_Y = 3'd3;
   localparam logic [2:0] CSR_POS_TOL     = 3'd4;
   localparam logic [2:0] CSR_HEAD_TOL    = 3'd5;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd6;
   localparam logic [2:0] CSR_FLAGS       = 3'd7;

   localparam logic [16:0] AGE_MAX = 17'h1FFFF;

   typedef enum logic [1:0] {
      MODE_INIT = 2'd0,
      MODE_HOLD = 2'd1,
      MODE_MOVE = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [23:0] fence_min_x;
      logic signed [23:0] fence_max_x;
      logic signed [23:0] fence_min_y;
      logic signed [23:0] fence_max_y;
      logic [15:0]        pos_tol;
      logic [31:0]        pos_tol_sq;
      logic [15:0]        head_tol;
      logic [15:0]        timeout;
      logic [1:0]         flags;      // bit0 fence enable, bit1 differential drive
   } cfg_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [15:0] heading;
   } pose_type;

   typedef struct packed {
      logic [1:0]         action;
      pose_type           pose;
      logic [2:0]         command_code;
      pose_type           goal;
      logic signed [15:0] speed_x;
      logic signed [15:0] speed_y;
      logic signed [15:0] turn_rate;
      logic               stamp_missing;
   } item_type;

   typedef struct packed {
      mode_type           mode;
      logic [2:0]         drive_action;
      logic signed [15:0] drive_vx;
      logic signed [15:0] drive_vy;
      logic signed [15:0] drive_wz;
      logic [1:0]         diag_level;
      logic [3:0]         diag_reason;
      logic               target_present;
      pose_type           target;
      logic               inside_fence;
   } result_type;

endpackage

`default_nettype wire

// ===== design/vms_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vms_csr import vms_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fence_min_x <= 24'sh800000;
         cfg_ff.fence_max_x <= 24'sh7FFFFF;
         cfg_ff.fence_min_y <= 24'sh800000;
         cfg_ff.fence_max_y <= 24'sh7FFFFF;
         cfg_ff.pos_tol     <= 16'd100;
         cfg_ff.pos_tol_sq  <= 32'd10000;
         cfg_ff.head_tol    <= 16'd1000;
         cfg_ff.timeout     <= 16'd50;
         cfg_ff.flags       <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FENCE_MIN_X: cfg_ff.fence_min_x <= csr_wdata;
            CSR_FENCE_MAX_X: cfg_ff.fence_max_x <= csr_wdata;
            CSR_FENCE_MIN_Y: cfg_ff.fence_min_y <= csr_wdata;
            CSR_FENCE_MAX_Y: cfg_ff.fence_max_y <= csr_wdata;
            CSR_POS_TOL: begin
               cfg_ff.pos_tol    <= csr_wdata[15:0];
               // keep the squared tolerance ready for the arrival compare
               cfg_ff.pos_tol_sq <= csr_wdata[15:0] * csr_wdata[15:0];
            end
            CSR_HEAD_TOL:    cfg_ff.head_tol <= csr_wdata[15:0];
            CSR_TIMEOUT:     cfg_ff.timeout  <= csr_wdata[15:0];
            CSR_FLAGS:       cfg_ff.flags    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/vms_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Track the goal-to-pose error whenever pose or goal moves, so a tick only
// has to add and compare.
module vms_geom import vms_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire pose_type cur_in,
   input  wire pose_type goal_in,
   input  wire cfg_type  cfg,
   output logic          near
);

   logic [24:0] dx, dy, ax, ay;
   logic [15:0] dh;
   logic [16:0] ah_in, ah_ff;
   logic [31:0] sq_x_in, sq_y_in, sq_x_ff, sq_y_ff;
   logic        far_in, far_ff;
   logic [32:0] sq_sum;

   always_comb begin
      dx      = {goal_in.x[23], goal_in.x} - {cur_in.x[23], cur_in.x};
      dy      = {goal_in.y[23], goal_in.y} - {cur_in.y[23], cur_in.y};
      ax      = dx[24] ? (25'd0 - dx) : dx;
      ay      = dy[24] ? (25'd0 - dy) : dy;
      // beyond 16 bits of error the tolerance can never be met
      far_in  = (|ax[24:16]) | (|ay[24:16]);
      sq_x_in = ax[15:0] * ax[15:0];
      sq_y_in = ay[15:0] * ay[15:0];
      dh      = goal_in.heading - cur_in.heading;
      ah_in   = dh[15] ? (17'd0 - {1'b1, dh}) : {1'b0, dh};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_x_ff <= '0;
         sq_y_ff <= '0;
         far_ff  <= 1'b0;
         ah_ff   <= '0;
      end else begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         far_ff  <= far_in;
         ah_ff   <= ah_in;
      end
   end

   assign sq_sum = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign near   = !far_ff && (sq_sum <= {1'b0, cfg.pos_tol_sq}) &&
                   (ah_ff <= {1'b0, cfg.head_tol});

endmodule

`default_nettype wire

// ===== design/vms_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vms_ctrl import vms_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   input  wire logic     near,
   output pose_type      cur_in,
   output pose_type      goal_in,
   output result_type    res
);

   mode_type           mode_ff, mode_in;
   logic               pose_valid_ff, pose_valid_in;
   pose_type           cur_ff;
   logic [2:0]         cmd_ff, cmd_in;
   pose_type           goal_ff;
   logic signed [15:0] spd_x_ff, spd_y_ff, spd_w_ff;
   logic signed [15:0] spd_x_in, spd_y_in, spd_w_in;
   logic               stamp_ff, stamp_in;
   logic [16:0]        age_ff, age_in;
   pose_type           hold_ff, hold_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [1:0]         lvl_ff, lvl_in;
   logic [3:0]         rsn_ff, rsn_in;

   logic               diff_drive, inside_now, breach, velocity, fall, keep_goal;

   function automatic logic in_fence(input pose_type p, input cfg_type c);
      in_fence = ($signed(p.x) >= $signed(c.fence_min_x)) &&
                 ($signed(p.x) <= $signed(c.fence_max_x)) &&
                 ($signed(p.y) >= $signed(c.fence_min_y)) &&
                 ($signed(p.y) <= $signed(c.fence_max_y));
   endfunction

   always_comb begin
      mode_in       = mode_ff;
      pose_valid_in = pose_valid_ff;
      cur_in        = cur_ff;
      cmd_in        = cmd_ff;
      goal_in       = goal_ff;
      spd_x_in      = spd_x_ff;
      spd_y_in      = spd_y_ff;
      spd_w_in      = spd_w_ff;
      stamp_in      = stamp_ff;
      age_in        = age_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      lvl_in        = lvl_ff;
      rsn_in        = rsn_ff;
      res           = '0;
      fall          = 1'b0;
      keep_goal     = 1'b0;
      diff_drive    = cfg.flags[1];
      inside_now    = !pose_valid_ff || in_fence(cur_ff, cfg);
      breach        = cfg.flags[0] && pose_valid_ff && !inside_now && (mode_ff != MODE_HOLD);
      velocity      = (cmd_ff == CMD_WORLD) || (cmd_ff == CMD_BODY);
      res.drive_action = DRV_NONE;

      if (fire) begin
         case (item.action)
            ACT_POSE: begin
               cur_in        = item.pose;
               pose_valid_in = 1'b1;
            end
            ACT_CMD: begin
               cmd_in   = item.command_code;
               goal_in  = item.goal;
               spd_x_in = item.speed_x;
               spd_y_in = item.speed_y;
               spd_w_in = item.turn_rate;
               stamp_in = item.stamp_missing;
               age_in   = '0;
               case (item.command_code)
                  CMD_HOLD: begin
                     lvl_in = LVL_OK;
                     rsn_in = RSN_OK;
                     if (pose_valid_ff) begin
                        hold_in       = cur_ff;
                        hold_valid_in = 1'b1;
                     end
                     mode_in = MODE_HOLD;
                  end
                  CMD_POINT, CMD_WORLD, CMD_BODY: begin
                     lvl_in  = LVL_OK;
                     rsn_in  = RSN_OK;
                     mode_in = MODE_MOVE;
                  end
                  CMD_GEO: begin
                     lvl_in  = LVL_WARN;
                     rsn_in  = RSN_GEO;
                     mode_in = MODE_MOVE;
                  end
                  default: begin
                     lvl_in = LVL_ERR;
                     rsn_in = RSN_UNKNOWN;
                  end
               endcase
            end
            ACT_TICK: begin
               age_in = (age_ff == AGE_MAX) ? age_ff : age_ff + 17'd1;
               if (breach) begin
                  lvl_in = LVL_ERR;
                  rsn_in = RSN_FENCE;
                  fall   = 1'b1;
                  res.drive_action = DRV_ZERO;
               end else if (mode_ff == MODE_HOLD) begin
                  res.drive_action = DRV_ZERO;
               end else if (mode_ff == MODE_MOVE) begin
                  if (velocity && stamp_ff) begin
                     lvl_in = LVL_ERR;
                     rsn_in = RSN_NO_STAMP;
                     fall   = 1'b1;
                     res.drive_action = DRV_ZERO;
                  end else if (velocity && (age_in > {1'b0, cfg.timeout})) begin
                     lvl_in = LVL_ERR;
                     rsn_in = RSN_TIMEOUT;
                     fall   = 1'b1;
                     res.drive_action = DRV_ZERO;
                  end else begin
                     case (cmd_ff)
                        CMD_POINT: begin
                           if (pose_valid_ff && near) begin
                              fall      = 1'b1;
                              keep_goal = 1'b1;
                              res.drive_action = DRV_ZERO;
                           end else begin
                              res.drive_action = DRV_POINT;
                           end
                        end
                        CMD_WORLD: begin
                           if (diff_drive) begin
                              lvl_in = LVL_ERR;
                              rsn_in = RSN_NO_WORLD;
                              fall   = 1'b1;
                              res.drive_action = DRV_ZERO;
                           end else begin
                              res.drive_action = DRV_WORLD;
                           end
                        end
                        CMD_BODY: begin
                           res.drive_vx = spd_x_ff;
                           res.drive_wz = spd_w_ff;
                           res.drive_vy = diff_drive ? 16'sd0 : spd_y_ff;
                           // lateral speed cannot be honored on a differential base
                           if (diff_drive && (spd_y_ff != 16'sd0)) begin
                              lvl_in = LVL_WARN;
                              rsn_in = RSN_LATERAL;
                           end
                           res.drive_action = DRV_BODY;
                        end
                        CMD_GEO: begin
                           lvl_in = LVL_WARN;
                           rsn_in = RSN_GEO;
                        end
                        default: begin
                           lvl_in = LVL_ERR;
                           rsn_in = RSN_BAD_MOVE;
                           fall   = 1'b1;
                           res.drive_action = DRV_ZERO;
                        end
                     endcase
                  end
               end

               if (fall) begin
                  if (keep_goal) begin
                     hold_in       = goal_ff;
                     hold_valid_in = 1'b1;
                  end else if (pose_valid_ff) begin
                     hold_in       = cur_ff;
                     hold_valid_in = 1'b1;
                  end
                  mode_in = MODE_HOLD;
                  cmd_in  = CMD_HOLD;
               end
            end
            default: ;
         endcase
      end

      res.mode        = mode_in;
      res.diag_level  = lvl_in;
      res.diag_reason = rsn_in;
      if (mode_in == MODE_MOVE && cmd_in == CMD_POINT) begin
         res.target_present = 1'b1;
         res.target         = goal_in;
      end else if (mode_in == MODE_HOLD && hold_valid_in) begin
         res.target_present = 1'b1;
         res.target         = hold_in;
      end
      res.inside_fence = !pose_valid_in || in_fence(cur_in, cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_INIT;
         pose_valid_ff <= 1'b0;
         cmd_ff        <= CMD_UNDEF;
         stamp_ff      <= 1'b0;
         age_ff        <= '0;
         hold_valid_ff <= 1'b0;
         lvl_ff        <= LVL_OK;
         rsn_ff        <= RSN_OK;
      end else begin
         mode_ff       <= mode_in;
         pose_valid_ff <= pose_valid_in;
         cmd_ff        <= cmd_in;
         stamp_ff      <= stamp_in;
         age_ff        <= age_in;
         hold_valid_ff <= hold_valid_in;
         lvl_ff        <= lvl_in;
         rsn_ff        <= rsn_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      goal_ff  <= goal_in;
      spd_x_ff <= spd_x_in;
      spd_y_ff <= spd_y_in;
      spd_w_ff <= spd_w_in;
      hold_ff  <= hold_in;
   end

   a_speeds_only_on_body: assert property (@(posedge clock) disable iff (reset)
      fire && (res.drive_action != DRV_BODY) |->
         (res.drive_vx == 16'sd0) && (res.drive_vy == 16'sd0) && (res.drive_wz == 16'sd0))
      else $error("velocity driven without body velocity action");

   a_hold_cmd_holds: assert property (@(posedge clock) disable iff (reset)
      fire && (item.action == ACT_CMD) && (item.command_code == CMD_HOLD) |=>
         (mode_ff == MODE_HOLD) && (cmd_ff == CMD_HOLD))
      else $error("hold command did not enter hold");

   a_age_saturates: assert property (@(posedge clock) disable iff (reset)
      (age_ff == AGE_MAX) && !(fire && (item.action == ACT_CMD)) |=> (age_ff == AGE_MAX))
      else $error("command age wrapped");

   a_no_target_in_init: assert property (@(posedge clock) disable iff (reset)
      fire && res.target_present |-> (res.mode != MODE_INIT))
      else $error("target reported in init mode");

endmodule

`default_nettype wire

// ===== design/vehicle_motion_supervisor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_ready  one pose, command or tick item
// rsp_*     out        rsp_valid/rsp_ready  status and drive action per item
// csr_*     in         csr_we               register index and write data
//
// An accepted beat lands in the input register; the decision logic runs on it
// once the output register is empty or draining, and the result is registered
// in the output register. One beat per cycle is sustained while rsp_ready is high.
// Synchronous reset returns the block to init mode with default registers; no
// clearing pass. A stalled result holds the output register, and the input
// register keeps accepting as long as the output register drains.
module vehicle_motion_supervisor import vms_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [23:0] req_pose_x,
   input  wire logic signed [23:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_heading,
   input  wire logic [2:0]         req_command_code,
   input  wire logic signed [23:0] req_goal_x,
   input  wire logic signed [23:0] req_goal_y,
   input  wire logic signed [15:0] req_goal_heading,
   input  wire logic signed [15:0] req_speed_x,
   input  wire logic signed [15:0] req_speed_y,
   input  wire logic signed [15:0] req_turn_rate,
   input  wire logic               req_stamp_missing,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_mode,
   output logic [2:0]              rsp_drive_action,
   output logic signed [15:0]      rsp_drive_vx,
   output logic signed [15:0]      rsp_drive_vy,
   output logic signed [15:0]      rsp_drive_wz,
   output logic [1:0]              rsp_diag_level,
   output logic [3:0]              rsp_diag_reason,
   output logic                    rsp_target_present,
   output logic signed [23:0]      rsp_target_x,
   output logic signed [23:0]      rsp_target_y,
   output logic signed [15:0]      rsp_target_heading,
   output logic                    rsp_inside_fence,

   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   cfg_type    cfg;
   item_type   s1_item_ff, s1_item_in;
   logic       s1_valid_ff, s1_valid_in;
   result_type rsp_ff, res;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire, near;
   pose_type   cur_in, goal_in;

   // Decision runs when the input register holds a beat and the output
   // register is empty or draining this cycle.
   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;

   always_comb begin
      s1_item_in.action        = req_action;
      s1_item_in.pose.x        = req_pose_x;
      s1_item_in.pose.y        = req_pose_y;
      s1_item_in.pose.heading  = req_pose_heading;
      s1_item_in.command_code  = req_command_code;
      s1_item_in.goal.x        = req_goal_x;
      s1_item_in.goal.y        = req_goal_y;
      s1_item_in.goal.heading  = req_goal_heading;
      s1_item_in.speed_x       = req_speed_x;
      s1_item_in.speed_y       = req_speed_y;
      s1_item_in.turn_rate     = req_turn_rate;
      s1_item_in.stamp_missing = req_stamp_missing;

      // advance on acceptance, drop once consumed, otherwise hold
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= s1_item_in;
      end
      if (fire) begin
         rsp_ff <= res;
      end
   end

   vms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vms_geom u_geom (
      .clock   (clock),
      .reset   (reset),
      .cur_in  (cur_in),
      .goal_in (goal_in),
      .cfg     (cfg),
      .near    (near)
   );

   vms_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .near    (near),
      .cur_in  (cur_in),
      .goal_in (goal_in),
      .res     (res)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = rsp_ff.mode;
   assign rsp_drive_action   = rsp_ff.drive_action;
   assign rsp_drive_vx       = rsp_ff.drive_vx;
   assign rsp_drive_vy       = rsp_ff.drive_vy;
   assign rsp_drive_wz       = rsp_ff.drive_wz;
   assign rsp_diag_level     = rsp_ff.diag_level;
   assign rsp_diag_reason    = rsp_ff.diag_reason;
   assign rsp_target_present = rsp_ff.target_present;
   assign rsp_target_x       = rsp_ff.target.x;
   assign rsp_target_y       = rsp_ff.target.y;
   assign rsp_target_heading = rsp_ff.target.heading;
   assign rsp_inside_fence   = rsp_ff.inside_fence;

endmodule

`default_nettype wire
